// File: sv/hbsc_pkg.sv
package hbsc_pkg;

  // field widths
  localparam int REQ_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 16;
  localparam int WORD_W  = 32;
  localparam int TBL_W   = 16;
  localparam int TT_W    = 21;

  // saturating packet counters
  localparam int COUNT_WIDTH = 16;

  // internal widths
  localparam int BITS_W  = $clog2(WORD_W);
  localparam int ONES_W  = 3;
  localparam int SRC_W   = 2 * BYTE_W;
  localparam int SCNT_W  = $clog2(SRC_W + 1);
  localparam int ALIGN_W = (COUNT_WIDTH > TBL_W) ? COUNT_WIDTH : TBL_W;
  localparam int TTX_W   = (COUNT_WIDTH + 6 > TT_W + 1) ? COUNT_WIDTH + 6 : TT_W + 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FLAG   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DATA   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CRC    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FINISH = 3'd4;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [ONES_W-1:0] STUFF_AT  = 3'd5;
  localparam int                ZERO_BIAS = 4;
  localparam logic [TT_W-1:0]   TT_MAX    = {TT_W{1'b1}};

  localparam logic [CRC_W-1:0] CRC_HI_MUL = 16'h1081;
  localparam logic [CRC_W-1:0] CRC_LO [16] = '{
    16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
    16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
  };

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SEND    = 4'b0010,
    ST_JUSTIFY = 4'b0100,
    ST_SUMMARY = 4'b1000
  } state_t;

  // sequencer to shift unit
  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_val;
    logic count;
  } shift_ctl_t;

  // shift unit to sequencer
  typedef struct packed {
    logic full_next;
    logic empty;
  } shift_sts_t;

  // sequencer to output register
  typedef struct packed {
    logic load;
    logic summary;
    logic last;
  } emit_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    logic [CRC_W-1:0]  hi;
    v  = crc[CRC_W-1 -: BYTE_W] ^ b;
    hi = CRC_HI_MUL * {12'd0, v[7:4]};
    return {crc[BYTE_W-1:0], {BYTE_W{1'b0}}} ^ CRC_LO[v[3:0]] ^ hi;
  endfunction

endpackage

// File: sv/hbsc_ifs.sv
interface hbsc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [hbsc_pkg::REQ_W-1:0]  req_type;
  logic [hbsc_pkg::BYTE_W-1:0] data_byte;
  modport source(output valid, req_type, data_byte, input ready);
  modport sink(input valid, req_type, data_byte, output ready);
endinterface

interface hbsc_res_if;
  logic                        valid;
  logic                        ready;
  logic [hbsc_pkg::WORD_W-1:0] word;
  logic                        is_summary;
  logic [hbsc_pkg::TBL_W-1:0]  total_bits_less_one;
  logic [hbsc_pkg::TT_W-1:0]   transfer_time_us;
  logic                        last;
  modport source(output valid, word, is_summary, total_bits_less_one, transfer_time_us,
                 last, input ready);
  modport sink(input valid, word, is_summary, total_bits_less_one, transfer_time_us,
               last, output ready);
endinterface

interface hbsc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hbsc_pkg::CRC_W-1:0] crc_init;
  modport source(output valid, crc_init, input ready);
  modport sink(input valid, crc_init, output ready);
endinterface

// File: sv/hbsc_shift_unit.sv
module hbsc_shift_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  hbsc_pkg::shift_ctl_t             ctl,
  output hbsc_pkg::shift_sts_t             sts,
  output logic [hbsc_pkg::WORD_W-1:0]      word_next,
  output logic [hbsc_pkg::COUNT_WIDTH-1:0] total_bits,
  output logic [hbsc_pkg::COUNT_WIDTH-1:0] total_ones
);

  logic [hbsc_pkg::WORD_W-1:0] partial_word;
  logic [hbsc_pkg::BITS_W-1:0] bits_in_word;

  assign word_next     = {ctl.bit_val, partial_word[hbsc_pkg::WORD_W-1:1]};
  assign sts.full_next = (bits_in_word == {hbsc_pkg::BITS_W{1'b1}});
  assign sts.empty     = (bits_in_word == '0);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      partial_word <= '0;
      bits_in_word <= '0;
      total_bits   <= '0;
      total_ones   <= '0;
    end else if (ctl.shift) begin
      // the word wraps to empty once it is handed out
      if (sts.full_next) begin
        partial_word <= '0;
      end else begin
        partial_word <= word_next;
      end
      bits_in_word <= bits_in_word + 1'b1;
      if (ctl.count && (total_bits != {hbsc_pkg::COUNT_WIDTH{1'b1}})) begin
        total_bits <= total_bits + 1'b1;
      end
      if (ctl.count && ctl.bit_val && (total_ones != {hbsc_pkg::COUNT_WIDTH{1'b1}})) begin
        total_ones <= total_ones + 1'b1;
      end
    end
  end

endmodule

// File: sv/hbsc_seq.sv
module hbsc_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [hbsc_pkg::REQ_W-1:0]  req_type,
  input  logic [hbsc_pkg::BYTE_W-1:0] data_byte,
  input  logic [hbsc_pkg::CRC_W-1:0]  crc_init,
  input  logic                        out_free,
  input  hbsc_pkg::shift_sts_t        sts,
  output hbsc_pkg::shift_ctl_t        ctl,
  output hbsc_pkg::emit_t             emit
);

  hbsc_pkg::state_t            state, state_next;
  logic [hbsc_pkg::SRC_W-1:0]  src, src_next;
  logic [hbsc_pkg::SCNT_W-1:0] cnt, cnt_next;
  logic                        stuffed, stuffed_next;
  logic                        pending, pending_next;
  logic [hbsc_pkg::ONES_W-1:0] ones_run, ones_run_next;
  logic [hbsc_pkg::CRC_W-1:0]  crc_reg, crc_reg_next;

  always_comb begin
    state_next    = state;
    src_next      = src;
    cnt_next      = cnt;
    stuffed_next  = stuffed;
    pending_next  = pending;
    ones_run_next = ones_run;
    crc_reg_next  = crc_reg;
    ctl           = '0;
    emit          = '0;
    cmd_ready     = 1'b0;
    case (state)
      hbsc_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (req_type)
            hbsc_pkg::REQ_START: begin
              ctl.clear     = 1'b1;
              ones_run_next = '0;
              crc_reg_next  = crc_init;
            end
            hbsc_pkg::REQ_FLAG: begin
              src_next     = {hbsc_pkg::FLAG_BYTE, {hbsc_pkg::BYTE_W{1'b0}}};
              cnt_next     = hbsc_pkg::SCNT_W'(hbsc_pkg::BYTE_W);
              stuffed_next = 1'b0;
              state_next   = hbsc_pkg::ST_SEND;
            end
            hbsc_pkg::REQ_DATA: begin
              crc_reg_next = hbsc_pkg::crc_step(crc_reg, data_byte);
              src_next     = {data_byte, {hbsc_pkg::BYTE_W{1'b0}}};
              cnt_next     = hbsc_pkg::SCNT_W'(hbsc_pkg::BYTE_W);
              stuffed_next = 1'b1;
              state_next   = hbsc_pkg::ST_SEND;
            end
            hbsc_pkg::REQ_CRC: begin
              src_next     = crc_reg;
              cnt_next     = hbsc_pkg::SCNT_W'(hbsc_pkg::SRC_W);
              stuffed_next = 1'b1;
              state_next   = hbsc_pkg::ST_SEND;
            end
            hbsc_pkg::REQ_FINISH: begin
              state_next = hbsc_pkg::ST_JUSTIFY;
            end
            default: begin
            end
          endcase
        end
      end
      hbsc_pkg::ST_SEND: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          ctl.count = 1'b1;
          emit.load = sts.full_next;
          emit.last = 1'b1;
          if (pending) begin
            // stuffed zero after five ones
            ctl.bit_val  = 1'b0;
            pending_next = 1'b0;
            if (cnt == '0) begin
              state_next = hbsc_pkg::ST_IDLE;
            end
          end else begin
            ctl.bit_val = src[hbsc_pkg::SRC_W-1];
            src_next    = {src[hbsc_pkg::SRC_W-2:0], 1'b0};
            cnt_next    = cnt - 1'b1;
            if (stuffed) begin
              if (src[hbsc_pkg::SRC_W-1]) begin
                if (ones_run == hbsc_pkg::STUFF_AT - 1'b1) begin
                  ones_run_next = '0;
                  pending_next  = 1'b1;
                end else begin
                  ones_run_next = ones_run + 1'b1;
                end
              end else begin
                ones_run_next = '0;
              end
            end
            if ((cnt == hbsc_pkg::SCNT_W'(1)) && !pending_next) begin
              state_next = hbsc_pkg::ST_IDLE;
            end
          end
        end
      end
      hbsc_pkg::ST_JUSTIFY: begin
        if (sts.empty) begin
          state_next = hbsc_pkg::ST_SUMMARY;
        end else if (out_free) begin
          ctl.shift = 1'b1;
          emit.load = sts.full_next;
        end
      end
      hbsc_pkg::ST_SUMMARY: begin
        if (out_free) begin
          emit.load    = 1'b1;
          emit.summary = 1'b1;
          emit.last    = 1'b1;
          state_next   = hbsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hbsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hbsc_pkg::ST_IDLE;
      cnt      <= '0;
      pending  <= 1'b0;
      ones_run <= '0;
      crc_reg  <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      pending  <= pending_next;
      ones_run <= ones_run_next;
      crc_reg  <= crc_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    src     <= src_next;
    stuffed <= stuffed_next;
  end

endmodule

// File: sv/hdlc_bit_stuff_crc_framer.sv
// channel  modport  moves                        payload
// cmd      sink     one request per handshake    req_type, data_byte
// frame    source   one result per handshake     word, is_summary, total_bits_less_one,
//                                                transfer_time_us, last
// cfg      sink     crc_init write, always ready crc_init
//
// one serial bit per cycle through the shared word shifter while the output is free;
// each request is accepted while idle; flag, data byte and crc append then shift out
// (finish: right-justify shifts the partial word one place a cycle, then the summary)
// cmd is ready only while the sequencer is idle; no clearing pass after reset
// a stalled frame output freezes the shifter until the held result is taken
// rst is synchronous, active high; crc_init resets to zero
module hdlc_bit_stuff_crc_framer (
  input  logic       clk,
  input  logic       rst,
  hbsc_cmd_if.sink   cmd,
  hbsc_res_if.source frame,
  hbsc_cfg_if.sink   cfg
);

  logic [hbsc_pkg::CRC_W-1:0]       crc_init;
  hbsc_pkg::shift_ctl_t             ctl;
  hbsc_pkg::shift_sts_t             sts;
  hbsc_pkg::emit_t                  emit;
  logic [hbsc_pkg::WORD_W-1:0]      word_next;
  logic [hbsc_pkg::COUNT_WIDTH-1:0] total_bits;
  logic [hbsc_pkg::COUNT_WIDTH-1:0] total_ones;
  logic                             out_free;

  // summary arithmetic
  logic [hbsc_pkg::ALIGN_W-1:0] tbl_ext;
  logic [hbsc_pkg::TTX_W-1:0]   zeros;
  logic [hbsc_pkg::TTX_W-1:0]   ones_ext;
  logic [hbsc_pkg::TTX_W-1:0]   tt_full;
  logic [hbsc_pkg::TT_W-1:0]    tt_sat;

  // config write register, taken at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init <= '0;
    end else if (cfg.valid) begin
      crc_init <= cfg.crc_init;
    end
  end

  hbsc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .req_type  (cmd.req_type),
    .data_byte (cmd.data_byte),
    .crc_init  (crc_init),
    .out_free  (out_free),
    .sts       (sts),
    .ctl       (ctl),
    .emit      (emit)
  );

  hbsc_shift_unit u_shift (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .word_next  (word_next),
    .total_bits (total_bits),
    .total_ones (total_ones)
  );

  // total bits minus one, zero for an empty packet
  assign tbl_ext = (total_bits == '0) ? '0
                                      : hbsc_pkg::ALIGN_W'(total_bits - 1'b1);

  // ((zeros + 4) * 2 + ones * 3) * 8, saturated to the field
  always_comb begin
    ones_ext = hbsc_pkg::TTX_W'(total_ones);
    if (total_bits >= total_ones) begin
      zeros = hbsc_pkg::TTX_W'(total_bits - total_ones);
    end else begin
      zeros = '0;
    end
    zeros   = zeros + hbsc_pkg::TTX_W'(hbsc_pkg::ZERO_BIAS);
    tt_full = ((zeros << 1) + (ones_ext << 1) + ones_ext) << 3;
    if (tt_full > hbsc_pkg::TTX_W'(hbsc_pkg::TT_MAX)) begin
      tt_sat = hbsc_pkg::TT_MAX;
    end else begin
      tt_sat = tt_full[hbsc_pkg::TT_W-1:0];
    end
  end

  // output register: frees up in the same cycle its result is taken
  assign out_free = !frame.valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (emit.load) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      frame.is_summary <= emit.summary;
      frame.last       <= emit.last;
      if (emit.summary) begin
        frame.word                <= '0;
        frame.total_bits_less_one <= tbl_ext[hbsc_pkg::TBL_W-1:0];
        frame.transfer_time_us    <= tt_sat;
      end else begin
        frame.word                <= word_next;
        frame.total_bits_less_one <= '0;
        frame.transfer_time_us    <= '0;
      end
    end
  end

endmodule

// File: sv/hbsc_checker.sv
module hbsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic [hbsc_pkg::REQ_W-1:0]  req_type,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [hbsc_pkg::WORD_W-1:0] word,
  input logic                        is_summary,
  input logic [hbsc_pkg::TBL_W-1:0]  total_bits_less_one,
  input logic [hbsc_pkg::TT_W-1:0]   transfer_time_us,
  input logic                        last
);

  // a held result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(word) && $stable(last))
    else $error("frame result changed while stalled");

  // a summary closes the finish request and carries no word
  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_summary |-> last && (word == '0))
    else $error("summary result malformed");

  // word results carry no totals
  a_word_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_summary |-> (total_bits_less_one == '0) && (transfer_time_us == '0))
    else $error("word result carries totals");

  // serial requests keep the block busy
  a_busy_after_send: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (req_type == hbsc_pkg::REQ_FLAG ||
      req_type == hbsc_pkg::REQ_DATA || req_type == hbsc_pkg::REQ_CRC ||
      req_type == hbsc_pkg::REQ_FINISH) |=> !cmd_ready)
    else $error("ready right after a serial request");

endmodule

bind hdlc_bit_stuff_crc_framer hbsc_checker u_hbsc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .cmd_valid           (cmd.valid),
  .cmd_ready           (cmd.ready),
  .req_type            (cmd.req_type),
  .res_valid           (frame.valid),
  .res_ready           (frame.ready),
  .word                (frame.word),
  .is_summary          (frame.is_summary),
  .total_bits_less_one (frame.total_bits_less_one),
  .transfer_time_us    (frame.transfer_time_us),
  .last                (frame.last)
);

// File: tb/sv/hbsc_frame_checker.sv
module hbsc_frame_checker
  import hbsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hbsc_cmd_if  cmd,
  hbsc_res_if  frame,
  hbsc_cfg_if  cfg,
  output int   fail_count,
  output int   frames_outstanding
);

  // reflected ccitt polynomial, one bit at a time
  localparam logic [CRC_W-1:0]  CRC_REFL_POLY = 16'h8408;
  localparam longint unsigned   CNT_SAT       = (64'd1 << COUNT_WIDTH) - 1;
  localparam int                LOG_CAP       = 100;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_summary;
    logic [TBL_W-1:0]  total_bits_less_one;
    logic [TT_W-1:0]   transfer_time_us;
    logic              last;
  } frame_res_t;

  // shadow of the framer state
  logic [WORD_W-1:0] shift_word;
  int unsigned       word_fill;
  int unsigned       ones_run;
  logic [CRC_W-1:0]  crc_acc;
  logic [CRC_W-1:0]  crc_seed;
  longint unsigned   bit_total;
  longint unsigned   one_total;

  frame_res_t frames_due[$];
  frame_res_t step_res[$];

  // byte term of the crc; same as the low-nibble lookup xor 0x1081 per high-nibble step
  function automatic logic [CRC_W-1:0] crc_byte_term(input logic [BYTE_W-1:0] v);
    logic [CRC_W-1:0] r;
    int i;
    r = {{(CRC_W-BYTE_W){1'b0}}, v};
    for (i = 0; i < BYTE_W; i++) r = r[0] ? ((r >> 1) ^ CRC_REFL_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    return {crc[BYTE_W-1:0], {BYTE_W{1'b0}}} ^ crc_byte_term(crc[CRC_W-1 -: BYTE_W] ^ b);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < LOG_CAP)
      $display("%0t frame %s: got 0x%0h want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic add_result(input logic [WORD_W-1:0] w, input logic summ,
                            input logic [TBL_W-1:0] tbl, input logic [TT_W-1:0] tt);
    frame_res_t r;
    if (step_res.size() < 2) begin
      r = '{w, summ, tbl, tt, 1'b0};
      step_res.push_back(r);
    end
  endtask

  task automatic put_bit(input logic b);
    shift_word = {b, shift_word[WORD_W-1:1]};
    if (b && one_total < CNT_SAT) one_total++;
    word_fill++;
    if (word_fill >= WORD_W) begin
      add_result(shift_word, 1'b0, '0, '0);
      word_fill  = 0;
      shift_word = '0;
    end
    if (bit_total < CNT_SAT) bit_total++;
  endtask

  // msb first, zero inserted after five ones
  task automatic put_stuffed_byte(input logic [BYTE_W-1:0] b);
    int i;
    for (i = BYTE_W - 1; i >= 0; i--) begin
      ones_run = b[i] ? ones_run + 1 : 0;
      put_bit(b[i]);
      if (ones_run >= STUFF_AT) begin
        ones_run = 0;
        put_bit(1'b0);
      end
    end
  endtask

  task automatic close_packet();
    longint unsigned zeros;
    longint unsigned tt;
    if (word_fill != 0) add_result(shift_word >> (WORD_W - word_fill), 1'b0, '0, '0);
    shift_word = '0;
    word_fill  = 0;
    zeros = ((bit_total >= one_total) ? bit_total - one_total : 0) + ZERO_BIAS;
    tt    = (zeros * 2 + one_total * 3) * 8;
    if (tt > TT_MAX) tt = TT_MAX;
    add_result('0, 1'b1, (bit_total == 0) ? '0 : TBL_W'(bit_total - 1), tt[TT_W-1:0]);
  endtask

  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] b);
    frame_res_t r;
    int i;
    step_res.delete();
    case (req)
      REQ_START: begin
        shift_word = '0;
        word_fill  = 0;
        ones_run   = 0;
        bit_total  = 0;
        one_total  = 0;
        crc_acc    = crc_seed;
      end
      REQ_FLAG: begin
        for (i = BYTE_W - 1; i >= 0; i--) put_bit(FLAG_BYTE[i]);
      end
      REQ_DATA: begin
        crc_acc = crc_fold(crc_acc, b);
        put_stuffed_byte(b);
      end
      REQ_CRC: begin
        put_stuffed_byte(crc_acc[CRC_W-1 -: BYTE_W]);
        put_stuffed_byte(crc_acc[BYTE_W-1:0]);
      end
      REQ_FINISH: close_packet();
      default: ;
    endcase
    for (i = 0; i < step_res.size(); i++) begin
      r      = step_res[i];
      r.last = (i == step_res.size() - 1);
      frames_due.push_back(r);
    end
  endtask

  task automatic check_result();
    frame_res_t got;
    frame_res_t want;
    got = '{frame.word, frame.is_summary, frame.total_bits_less_one,
            frame.transfer_time_us, frame.last};
    if (frames_due.size() == 0) begin
      report_mismatch("result with nothing pending, word", got.word, '0);
    end else begin
      want = frames_due.pop_front();
      if (got.word !== want.word) report_mismatch("word", got.word, want.word);
      if (got.is_summary !== want.is_summary)
        report_mismatch("is_summary", got.is_summary, want.is_summary);
      if (got.total_bits_less_one !== want.total_bits_less_one)
        report_mismatch("total_bits_less_one", got.total_bits_less_one,
                        want.total_bits_less_one);
      if (got.transfer_time_us !== want.transfer_time_us)
        report_mismatch("transfer_time_us", got.transfer_time_us, want.transfer_time_us);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shift_word = '0;
      word_fill  = 0;
      ones_run   = 0;
      crc_acc    = '0;
      crc_seed   = '0;
      bit_total  = 0;
      one_total  = 0;
      fail_count = 0;
      frames_due.delete();
    end else begin
      if (frame.valid && frame.ready) check_result();
      if (cfg.valid && cfg.ready) crc_seed = cfg.crc_init;
      if (cmd.valid && cmd.ready) predict_request(cmd.req_type, cmd.data_byte);
    end
    frames_outstanding <= frames_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import hbsc_pkg::*;

  // top code of the 3-bit request field; codes above finish are unused
  localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;

  localparam int unsigned PHASE_ITEMS = 250;   // counted requests per crc_init setting
  localparam int unsigned LONG_BYTES  = 250;   // bytes in the long packet of mostly ones
  localparam int unsigned DRAIN_IDLE  = 48;    // covers the longest finish
  localparam int unsigned LIMIT       = 3000000;

  logic clk;
  logic rst;

  int          n_fail;
  int          n_outstanding;
  int unsigned n_items;      // requests with a defined code sent in this phase
  bit          sender_calm;  // stretch of back-to-back requests

  hbsc_cmd_if cmd_bus();
  hbsc_res_if frame_bus();
  hbsc_cfg_if cfg_bus();

  hdlc_bit_stuff_crc_framer i_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_bus),
    .frame (frame_bus),
    .cfg   (cfg_bus)
  );

  // predicts the frame words and summaries and compares every accepted result
  hbsc_frame_checker i_chk (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd_bus),
    .frame              (frame_bus),
    .cfg                (cfg_bus),
    .fail_count         (n_fail),
    .frames_outstanding (n_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly a few cycles, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // one request; with no gap it returns at the accepting edge with valid left high
  task send_req(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    cmd_bus.valid     <= 1'b1;
    cmd_bus.req_type  <= req;
    cmd_bus.data_byte <= b;
    do @(posedge clk); while (!cmd_bus.ready);
    if (req <= REQ_FINISH) n_items++;
    gap = (sender_calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if ($urandom_range(0, 99) == 0) sender_calm = !sender_calm;
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // crc_init write; only called with the framer idle
  task write_crc_init(input logic [CRC_W-1:0] v);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.crc_init <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // wait until every predicted result is taken, then let silent requests finish
  task drain();
    do @(posedge clk); while (n_outstanding != 0);
    repeat (DRAIN_IDLE) @(posedge clk);
  endtask

  // result side: random stalls, with calm stretches where ready stays high
  initial begin
    int unsigned hold;
    bit          rx_calm;
    frame_bus.ready = 1'b0;
    hold    = 0;
    rx_calm = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (hold != 0) begin
        hold--;
        frame_bus.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        hold = idle_len() - 1;
        frame_bus.ready <= 1'b0;
      end else begin
        frame_bus.ready <= 1'b1;
      end
    end
  end

  // timeout guard
  initial begin
    int unsigned n_cyc;
    n_cyc = 0;
    while (n_cyc < LIMIT) begin
      @(posedge clk);
      n_cyc++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    logic [CRC_W-1:0]  seeds[5];
    logic [BYTE_W-1:0] b;
    int unsigned       k;
    int unsigned       ph;
    int unsigned       n_data;

    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.req_type  = REQ_START;
    cmd_bus.data_byte = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.crc_init  = '0;
    sender_calm       = 1'b0;
    n_items           = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, crc_init still at its reset value of zero
    send_req(REQ_START, 8'hFF);
    send_req(REQ_FLAG, 8'h00);
    send_req(REQ_DATA, 8'h00);
    send_req(REQ_DATA, 8'hFF);     // ones run spans the byte, stuffing inside
    send_req(REQ_DATA, 8'h7C);     // exactly five ones, stuffed zero after them
    send_req(REQ_DATA, 8'hF8);
    send_req(REQ_CRC, 8'h00);
    send_req(REQ_FINISH, 8'h00);   // partial word then summary
    send_req(REQ_FINISH, 8'h00);   // empty word: summary only, totals kept
    send_req(REQ_START, 8'h00);
    send_req(REQ_FINISH, 8'h00);   // packet with no bits at all
    // unused codes must be swallowed without a result
    for (k = REQ_FINISH + 1; k <= REQ_CODE_MAX; k++) send_req(REQ_W'(k), 8'hA5);
    send_req(REQ_START, 8'h5A);
    repeat (4) send_req(REQ_FLAG, 8'hFF);  // exactly one full word, nothing left over
    send_req(REQ_FINISH, 8'h00);
    send_req(REQ_DATA, 8'h3F);     // ones run left open before the flag
    send_req(REQ_FLAG, 8'h00);     // flag keeps the run count
    send_req(REQ_DATA, 8'hE0);
    send_req(REQ_CRC, 8'h00);
    send_req(REQ_FINISH, 8'h00);
    cmd_bus.valid <= 1'b0;
    drain();

    // random packets under several crc_init settings, extremes first
    seeds = '{16'hFFFF, 16'h0000, CRC_W'($urandom_range(0, 16'hFFFF)), 16'h8000,
              CRC_W'($urandom_range(0, 16'hFFFF))};
    for (ph = 0; ph < 5; ph++) begin
      write_crc_init(seeds[ph]);
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any code, unused ones included
          repeat ($urandom_range(1, 4))
            send_req(REQ_W'($urandom_range(0, REQ_CODE_MAX)), BYTE_W'($urandom_range(0, 255)));
        end else begin
          // well-formed packet with random content, sometimes broken
          send_req(REQ_START, BYTE_W'($urandom_range(0, 255)));
          if ($urandom_range(0, 7) != 0) send_req(REQ_FLAG, BYTE_W'($urandom_range(0, 255)));
          n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
          for (k = 0; k < n_data; k++) begin
            // bias toward long runs of ones so stuffing fires often
            case ($urandom_range(0, 3))
              0:       b = 8'hFF;
              1:       b = 8'hFF >> $urandom_range(1, 4);
              2:       b = 8'hFF << $urandom_range(1, 4);
              default: b = BYTE_W'($urandom_range(0, 255));
            endcase
            send_req(REQ_DATA, b);
            if ($urandom_range(0, 15) == 0) send_req(REQ_FLAG, BYTE_W'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 7) != 0) send_req(REQ_CRC, BYTE_W'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) != 0) send_req(REQ_FLAG, BYTE_W'($urandom_range(0, 255)));
          // a missing finish leaves the packet to be cut off by the next start
          if ($urandom_range(0, 9) != 0) send_req(REQ_FINISH, BYTE_W'($urandom_range(0, 255)));
        end
      end
      cmd_bus.valid <= 1'b0;
      drain();
    end

    // one long packet of mostly ones, with a summary partway through
    write_crc_init(CRC_W'($urandom_range(0, 16'hFFFF)));
    send_req(REQ_START, 8'h00);
    send_req(REQ_FLAG, 8'h00);
    for (k = 0; k < LONG_BYTES; k++) begin
      send_req(REQ_DATA, ($urandom_range(0, 19) == 0) ? BYTE_W'($urandom_range(0, 255)) : 8'hFF);
      // summary midway; totals keep counting after it
      if (k == LONG_BYTES / 2) send_req(REQ_FINISH, 8'h00);
    end
    send_req(REQ_CRC, 8'h00);
    send_req(REQ_FINISH, 8'h00);
    cmd_bus.valid <= 1'b0;
    drain();

    if (n_fail == 0 && n_outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/hbsc_pkg.sv
sv/hbsc_ifs.sv
sv/hbsc_shift_unit.sv
sv/hbsc_seq.sv
sv/hdlc_bit_stuff_crc_framer.sv
sv/hbsc_checker.sv
tb/sv/hbsc_frame_checker.sv
tb/sv/tb_top.sv
